// ===== hw/rtl/wfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Wake-up frame builder package
// Shared payload types, operation codes and the CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package wfb_pkg;

  // Operation codes carried in the op field.
  localparam logic [1:0] OP_WAKE    = 2'd0;
  localparam logic [1:0] OP_DATA    = 2'd1;
  localparam logic [1:0] OP_PAYLOAD = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WAKE_TYPE = 2'd0;
  localparam logic [1:0] CFG_DATA_TYPE = 2'd1;
  localparam logic [1:0] CFG_ACK_REQ   = 2'd2;

  // CRC-8 generator polynomial x^8 + x^2 + x + 1.
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Length byte of a wake frame: wake time plus CRC.
  localparam logic [7:0] WAKE_LEN = 8'd3;

  // Most plain bytes that one input item can queue.
  localparam int unsigned BURST_DEPTH = 6;

  // Input item fields.
  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  dest;
    logic [9:0]  src;
    logic        seq;
    logic        ack_req;
    logic [15:0] wake_ms;
    logic [7:0]  length;
    logic [7:0]  data_byte;
  } in_t;

  // Result item fields.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       error;
  } out_t;

  // Configuration registers.
  typedef struct packed {
    logic [2:0] wake_type_code;
    logic [2:0] data_type_code;
    logic [2:0] ack_request_code;
  } cfg_t;

  // What closes a burst after its plain bytes.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_CRC,
    TAIL_ERR
  } tail_e;

  // Bytes produced by one input item, handed to the serializer.
  typedef struct packed {
    logic [BURST_DEPTH-1:0][7:0] bytes;
    logic [2:0]                  cnt;
    tail_e                       tail;
    logic                        crc_clear;
  } burst_t;

  // Folds one byte into the CRC, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wfb_framer.sv =====
// ----------------------------------------------------------------------------
// Wake-up frame builder: framer
// Registers the input item, tracks the open data frame and turns each item
// into a burst of frame bytes for the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module wfb_framer #(
  parameter int unsigned MAX_FRAME_LEN = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire wfb_pkg::in_t  in_data_i,
  input  wire wfb_pkg::cfg_t cfg_i,
  input  wire logic          free_i,
  output logic               load_o,
  output wfb_pkg::burst_t    burst_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

  logic         in_valid_q;
  wfb_pkg::in_t in_q;
  logic         open_q, open_d;
  logic [7:0]   left_q, left_d;

  logic [2:0]   flags;
  logic [7:0]   len_eff;
  logic [7:0]   left_dec;
  logic [7:0]   hdr0, hdr1, hdr2;

  // The held item moves on when the serializer can take its burst.
  assign load_o     = in_valid_q && free_i;
  assign in_ready_o = !in_valid_q || free_i;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Header fields.
  always_comb begin
    if (in_q.op == wfb_pkg::OP_WAKE) begin
      flags = cfg_i.wake_type_code;
    end else begin
      flags = cfg_i.data_type_code | (in_q.ack_req ? cfg_i.ack_request_code : 3'd0);
    end
    hdr0     = in_q.dest[9:2];
    hdr1     = {in_q.dest[1:0], in_q.src[9:4]};
    hdr2     = {in_q.src[3:0], flags, in_q.seq};
    len_eff  = (in_q.length == 8'd0) ? 8'd1 : in_q.length;
    left_dec = left_q - 8'd1;
  end

  // Burst build and frame state update.
  always_comb begin
    burst_o           = '0;
    burst_o.tail      = wfb_pkg::TAIL_NONE;
    open_d            = open_q;
    left_d            = left_q;
    case (in_q.op)
      wfb_pkg::OP_WAKE: begin
        burst_o.bytes[0]  = hdr0;
        burst_o.bytes[1]  = hdr1;
        burst_o.bytes[2]  = hdr2;
        burst_o.bytes[3]  = wfb_pkg::WAKE_LEN;
        burst_o.bytes[4]  = in_q.wake_ms[15:8];
        burst_o.bytes[5]  = in_q.wake_ms[7:0];
        burst_o.cnt       = 3'd6;
        burst_o.tail      = wfb_pkg::TAIL_CRC;
        burst_o.crc_clear = 1'b1;
        open_d            = 1'b0;
        left_d            = 8'd0;
      end
      wfb_pkg::OP_DATA: begin
        burst_o.crc_clear = 1'b1;
        if (in_q.length > MaxLen) begin
          burst_o.tail = wfb_pkg::TAIL_ERR;
          open_d       = 1'b0;
          left_d       = 8'd0;
        end else begin
          burst_o.bytes[0] = hdr0;
          burst_o.bytes[1] = hdr1;
          burst_o.bytes[2] = hdr2;
          burst_o.bytes[3] = len_eff;
          burst_o.cnt      = 3'd4;
          // An ack frame carries its CRC right after the length byte.
          if (len_eff == 8'd1) begin
            burst_o.tail = wfb_pkg::TAIL_CRC;
            open_d       = 1'b0;
            left_d       = 8'd0;
          end else begin
            open_d = 1'b1;
            left_d = len_eff - 8'd1;
          end
        end
      end
      wfb_pkg::OP_PAYLOAD: begin
        // Payload without an open frame is flagged and leaves state alone.
        if (!open_q || left_q == 8'd0) begin
          burst_o.tail = wfb_pkg::TAIL_ERR;
        end else begin
          burst_o.bytes[0] = in_q.data_byte;
          burst_o.cnt      = 3'd1;
          left_d           = left_dec;
          if (left_dec == 8'd0) begin
            burst_o.tail = wfb_pkg::TAIL_CRC;
            open_d       = 1'b0;
          end
        end
      end
      default: begin
        // Unused op: no bytes, no state change.
      end
    endcase
  end

  // Frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
    end else if (load_o) begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wakeup_frame_builder_crc8_core.sv =====
// Timing: an accepted item waits in the framer's input register, moves into the burst register
// when the serializer is free, and its first result beat is driven from there.
// Throughput: the output moves one beat per cycle while out_ready_i is high; an item's
// result beats are: wake 7, data header 4, 5 or 1 on error, payload 1 or 2, op 3 none.
// Input takes an item every cycle while results are single beats and the output is ready.
// Reset clears the frame state, the CRC and the queues, and loads the register defaults.
// ----------------------------------------------------------------------------
// Wake-up frame builder with CRC-8
// Turns header and payload items into a byte stream with CRC-8 (poly 0x07).
// ----------------------------------------------------------------------------
`default_nettype none

module wakeup_frame_builder_crc8_core #(
  parameter int unsigned MAX_FRAME_LEN = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire wfb_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output wfb_pkg::out_t      out_data_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [2:0]    cfg_data_i
);

  wfb_pkg::cfg_t   cfg_q;
  wfb_pkg::burst_t burst, burst_q;
  logic            load, free;
  logic [2:0]      pos_q, total_q;
  logic [7:0]      crc_q, crc_d;
  logic            take, last_take, in_body;
  logic [7:0]      cur_byte;

  // Configuration registers, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wake_type_code   <= 3'd1;
      cfg_q.data_type_code   <= 3'd2;
      cfg_q.ack_request_code <= 3'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wfb_pkg::CFG_WAKE_TYPE: cfg_q.wake_type_code   <= cfg_data_i;
        wfb_pkg::CFG_DATA_TYPE: cfg_q.data_type_code   <= cfg_data_i;
        wfb_pkg::CFG_ACK_REQ:   cfg_q.ack_request_code <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  wfb_framer #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .free_i     (free),
    .load_o     (load),
    .burst_o    (burst)
  );

  // Serializer handshake.
  assign out_valid_o = (pos_q != total_q);
  assign take        = out_valid_o && out_ready_i;
  assign last_take   = take && ((pos_q + 3'd1) == total_q);
  assign free        = !out_valid_o || last_take;
  assign in_body     = (pos_q < burst_q.cnt);

  // Current beat: plain bytes first, then the closing CRC or error beat.
  always_comb begin
    cur_byte   = 8'd0;
    out_data_o = '0;
    if (in_body) begin
      cur_byte              = burst_q.bytes[pos_q];
      out_data_o.frame_byte = cur_byte;
    end else if (burst_q.tail == wfb_pkg::TAIL_CRC) begin
      out_data_o.frame_byte = crc_q;
      out_data_o.last_byte  = 1'b1;
    end else begin
      out_data_o.last_byte = 1'b1;
      out_data_o.error     = 1'b1;
    end
  end

  // Running CRC folds each plain byte as it leaves; a new frame starts at zero.
  always_comb begin
    crc_d = crc_q;
    if (take) begin
      if (in_body) begin
        crc_d = wfb_pkg::crc8_byte(crc_q, cur_byte);
      end else if (burst_q.tail == wfb_pkg::TAIL_CRC) begin
        crc_d = 8'd0;
      end
    end
    if (load && burst.crc_clear) begin
      crc_d = 8'd0;
    end
  end

  // Burst register and beat position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 3'd0;
      total_q <= 3'd0;
      crc_q   <= 8'd0;
      burst_q <= '0;
    end else begin
      crc_q <= crc_d;
      if (load) begin
        pos_q   <= 3'd0;
        total_q <= burst.cnt + ((burst.tail != wfb_pkg::TAIL_NONE) ? 3'd1 : 3'd0);
        burst_q <= burst;
      end else if (take) begin
        pos_q <= pos_q + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wake-up frame builder testbench
// Sends wake, data and payload items through the valid/ready input and checks
// every output beat against a built-in model of the framing and CRC-8. The run
// starts with a walk through a fixed stimulus list and then sends random
// frames under several flag-code settings, with random idling on both sides.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned   MAX_LEN      = 64;
  localparam logic [1:0]    OP_UNUSED    = 2'd3;
  localparam int unsigned   SETTLE_TICKS = 8;
  localparam int unsigned   CYCLE_LIMIT  = 300000;
  localparam wfb_pkg::out_t ERR_BEAT     = {8'h00, 1'b1, 1'b1};

  // One line of the fixed stimulus list; err_row marks a typed-in error beat.
  typedef struct {
    wfb_pkg::in_t it;
    bit           err_row;
  } stim_row_t;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  wfb_pkg::in_t  in_data   = '0;
  logic          out_ready = 1'b0;
  logic          cfg_valid = 1'b0;
  logic [1:0]    cfg_index = wfb_pkg::CFG_WAKE_TYPE;
  logic [2:0]    cfg_data  = '0;
  logic          in_ready;
  logic          out_valid;
  wfb_pkg::out_t out_data;
  logic          cfg_ready;

  // Frame state and flag codes as the block should hold them.
  logic [7:0] crc_acc    = 8'h00;
  logic [7:0] pay_left   = 8'h00;
  logic       frame_busy = 1'b0;
  logic [2:0] wake_flags = 3'd1;
  logic [2:0] data_flags = 3'd2;
  logic [2:0] ack_flags  = 3'd4;

  wfb_pkg::out_t frame_beats[$];
  wfb_pkg::out_t new_beats[$];
  stim_row_t     stim_list[$];

  int unsigned err_cnt    = 0;
  int unsigned items_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned crc_beats  = 0;
  int unsigned err_beats  = 0;
  int unsigned settings   = 1;
  int unsigned cycles     = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned stall_left = 0;

  wakeup_frame_builder_crc8_core #(
    .MAX_FRAME_LEN(MAX_LEN)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles,
               frame_beats.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    return ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  // CRC-8, poly 0x07, one message bit at a time from the MSB.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0} ^ (fb ? wfb_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // Works out the beats that one item produces and advances the frame state.
  function automatic void build_beats(input wfb_pkg::in_t it);
    logic [7:0] plain[$];
    logic [7:0] crc;
    logic [7:0] len;
    logic [2:0] flags;
    bit         close;
    new_beats.delete();
    crc   = 8'h00;
    close = 1'b0;
    case (it.op)
      wfb_pkg::OP_WAKE: begin
        frame_busy = 1'b0;
        pay_left   = 8'h00;
        crc_acc    = 8'h00;
        plain.push_back(it.dest[9:2]);
        plain.push_back({it.dest[1:0], it.src[9:4]});
        plain.push_back({it.src[3:0], wake_flags, it.seq});
        plain.push_back(wfb_pkg::WAKE_LEN);
        plain.push_back(it.wake_ms[15:8]);
        plain.push_back(it.wake_ms[7:0]);
        close = 1'b1;
      end
      wfb_pkg::OP_DATA: begin
        if (it.length > MAX_LEN) begin
          frame_busy = 1'b0;
          pay_left   = 8'h00;
          new_beats.push_back(ERR_BEAT);
        end else begin
          // An ack frame of length zero goes out as length one.
          len   = (it.length == 8'd0) ? 8'd1 : it.length;
          flags = data_flags | (it.ack_req ? ack_flags : 3'd0);
          plain.push_back(it.dest[9:2]);
          plain.push_back({it.dest[1:0], it.src[9:4]});
          plain.push_back({it.src[3:0], flags, it.seq});
          plain.push_back(len);
          if (len == 8'd1) begin
            close      = 1'b1;
            frame_busy = 1'b0;
            pay_left   = 8'h00;
          end else begin
            frame_busy = 1'b1;
            pay_left   = len - 8'd1;
          end
        end
      end
      wfb_pkg::OP_PAYLOAD: begin
        if (!frame_busy || pay_left == 8'h00) begin
          new_beats.push_back(ERR_BEAT);
        end else begin
          crc = crc_acc;
          plain.push_back(it.data_byte);
          pay_left = pay_left - 8'd1;
          if (pay_left == 8'h00) begin
            close      = 1'b1;
            frame_busy = 1'b0;
          end
        end
      end
      default: ;
    endcase
    foreach (plain[i]) begin
      crc = crc8_next(crc, plain[i]);
      new_beats.push_back({plain[i], 1'b0, 1'b0});
    end
    if (it.op == wfb_pkg::OP_DATA || (it.op == wfb_pkg::OP_PAYLOAD && plain.size() != 0)) begin
      crc_acc = frame_busy ? crc : 8'h00;
    end
    if (close) begin
      new_beats.push_back({crc, 1'b1, 1'b0});
    end
  endfunction

  function automatic wfb_pkg::in_t rand_item(input logic [1:0] op);
    wfb_pkg::in_t it;
    it.op        = op;
    it.dest      = 10'($urandom);
    it.src       = 10'($urandom);
    it.seq       = 1'($urandom);
    it.ack_req   = 1'($urandom);
    it.wake_ms   = 16'($urandom);
    it.length    = 8'($urandom);
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  function automatic stim_row_t row(input logic [1:0] op, input logic [9:0] dest,
                                    input logic [9:0] src, input logic seq,
                                    input logic ack, input logic [15:0] ms,
                                    input logic [7:0] len, input logic [7:0] db,
                                    input bit err_row);
    stim_row_t r;
    r.it      = '{op: op, dest: dest, src: src, seq: seq, ack_req: ack, wake_ms: ms,
                  length: len, data_byte: db};
    r.err_row = err_row;
    return r;
  endfunction

  task automatic report(input string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Offers one item, waits until the block takes it, and queues the beats it should cause.
  task automatic send(input wfb_pkg::in_t it, input bit err_row);
    int unsigned gap;
    gap = (idle_pct != 0 && $urandom_range(99) < idle_pct) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    build_beats(it);
    if (err_row) begin
      frame_beats.push_back(ERR_BEAT);
    end else begin
      foreach (new_beats[i]) frame_beats.push_back(new_beats[i]);
    end
    if (it.op != OP_UNUSED) items_sent++;
  endtask

  // Stops sending until every expected beat is out and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (frame_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Writes all three flag codes back to back while the block is idle.
  task automatic apply_setting(input logic [2:0] w, input logic [2:0] d,
                               input logic [2:0] a);
    logic [1:0] regs[3];
    logic [2:0] vals[3];
    regs = '{wfb_pkg::CFG_WAKE_TYPE, wfb_pkg::CFG_DATA_TYPE, wfb_pkg::CFG_ACK_REQ};
    vals = '{w, d, a};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (regs[i])
        wfb_pkg::CFG_WAKE_TYPE: wake_flags = vals[i];
        wfb_pkg::CFG_DATA_TYPE: data_flags = vals[i];
        wfb_pkg::CFG_ACK_REQ:   ack_flags  = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Random traffic: mostly whole frames, some cut short or followed by a
  // stray payload, and the rest loose items of any kind.
  task automatic run_random(input int unsigned n);
    int unsigned  stop;
    int unsigned  r;
    int unsigned  len;
    int unsigned  pay;
    wfb_pkg::in_t it;
    stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(39) == 0) settle();
      r = $urandom_range(99);
      if (r < 25) begin
        send(rand_item(wfb_pkg::OP_WAKE), 1'b0);
      end else if (r < 85) begin
        it        = rand_item(wfb_pkg::OP_DATA);
        len       = ($urandom_range(14) == 0) ? $urandom_range(9, MAX_LEN)
                                              : $urandom_range(0, 8);
        it.length = 8'(len);
        send(it, 1'b0);
        pay = (len > 1) ? len - 1 : 0;
        if (pay != 0 && $urandom_range(9) == 0) pay = $urandom_range(0, pay - 1);
        repeat (pay) send(rand_item(wfb_pkg::OP_PAYLOAD), 1'b0);
        if ($urandom_range(9) == 0) send(rand_item(wfb_pkg::OP_PAYLOAD), 1'b0);
      end else begin
        send(rand_item(2'($urandom_range(3))), 1'b0);
      end
    end
  endtask

  // Output side: random back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each output beat is checked against the oldest expected beat.
  always @(posedge clk) begin : beat_check
    wfb_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (out_data.last_byte && !out_data.error) crc_beats++;
      if (out_data.error) err_beats++;
      if (frame_beats.size() == 0) begin
        report($sformatf("beat %0h arrived with nothing expected", out_data));
      end else begin
        want = frame_beats.pop_front();
        if (out_data.frame_byte !== want.frame_byte)
          report($sformatf("frame_byte %0h, expected %0h", out_data.frame_byte,
                           want.frame_byte));
        if (out_data.last_byte !== want.last_byte)
          report($sformatf("last_byte %0b, expected %0b", out_data.last_byte,
                           want.last_byte));
        if (out_data.error !== want.error)
          report($sformatf("error %0b, expected %0b", out_data.error, want.error));
      end
    end
  end

  initial begin
    // Fixed list: extremes, ack frames, abandoned frames, errors, unused op.
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'h5a, 1));
    stim_list.push_back(row(wfb_pkg::OP_WAKE, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'h00, 0));
    stim_list.push_back(row(wfb_pkg::OP_WAKE, 10'h3ff, 10'h3ff, 1, 1, 16'hffff, 8'hff,
                            8'hff, 0));
    stim_list.push_back(row(wfb_pkg::OP_DATA, 10'h3ff, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'h00, 0));
    stim_list.push_back(row(wfb_pkg::OP_DATA, 10'h000, 10'h3ff, 1, 1, 16'h0000, 8'd1,
                            8'h00, 0));
    stim_list.push_back(row(wfb_pkg::OP_DATA, 10'h2aa, 10'h155, 0, 1, 16'h0000, 8'd2,
                            8'h00, 0));
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'hff, 0));
    stim_list.push_back(row(wfb_pkg::OP_DATA, 10'h155, 10'h2aa, 1, 0, 16'h0000, 8'd64,
                            8'h00, 0));
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'h00, 0));
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'h80, 0));
    stim_list.push_back(row(OP_UNUSED, 10'h3ff, 10'h3ff, 1, 1, 16'hffff, 8'hff, 8'hff, 0));
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'ha5, 0));
    stim_list.push_back(row(wfb_pkg::OP_DATA, 10'h001, 10'h002, 0, 0, 16'h0000, 8'd3,
                            8'h00, 0));
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'h01, 0));
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'hfe, 0));
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'h33, 1));
    stim_list.push_back(row(wfb_pkg::OP_DATA, 10'h0f0, 10'h00f, 0, 0, 16'h0000, 8'd65,
                            8'h00, 1));
    stim_list.push_back(row(wfb_pkg::OP_DATA, 10'h000, 10'h000, 0, 1, 16'h0000, 8'd4,
                            8'h00, 0));
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'h11, 0));
    stim_list.push_back(row(wfb_pkg::OP_DATA, 10'h3ff, 10'h3ff, 1, 1, 16'h0000, 8'd255,
                            8'h00, 1));
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'h22, 1));
    stim_list.push_back(row(wfb_pkg::OP_DATA, 10'h123, 10'h321, 0, 0, 16'h0000, 8'd2,
                            8'h00, 0));
    stim_list.push_back(row(wfb_pkg::OP_WAKE, 10'h200, 10'h001, 0, 0, 16'h1234, 8'd0,
                            8'h00, 0));
    stim_list.push_back(row(wfb_pkg::OP_PAYLOAD, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0,
                            8'h44, 1));
    stim_list.push_back(row(OP_UNUSED, 10'h000, 10'h000, 0, 0, 16'h0000, 8'd0, 8'h00, 0));

    // Hold reset, then release it.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fixed list under the reset flag codes.
    idle_pct  = 20;
    stall_pct = 20;
    foreach (stim_list[i]) send(stim_list[i].it, stim_list[i].err_row);
    settle();

    // All-ones codes, both sides at full rate.
    apply_setting(3'd7, 3'd7, 3'd7);
    idle_pct  = 0;
    stall_pct = 0;
    run_random(25);
    settle();

    // All-zero codes, moderate idling.
    apply_setting(3'd0, 3'd0, 3'd0);
    idle_pct  = 30;
    stall_pct = 30;
    run_random(25);
    settle();

    // Random codes, heavy idling.
    apply_setting(3'($urandom), 3'($urandom), 3'($urandom));
    idle_pct  = 60;
    stall_pct = 50;
    run_random(25);
    settle();

    // Random codes again, light idling.
    apply_setting(3'($urandom), 3'($urandom), 3'($urandom));
    idle_pct  = 10;
    stall_pct = 15;
    run_random(25);
    settle();

    $display("%0d items sent under %0d flag-code settings, all-zero and all-one included",
             items_sent, settings);
    $display("%0d beats checked: %0d frames closed by a CRC beat, %0d error beats",
             beats_seen, crc_beats, err_beats);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
